### hw/rtl/tkcet_pkg.sv
// Package for the top-k class evidence tracker.
// Holds the slot count, codes, reset values and the structs passed between modules.
// No dependencies.
package tkcet_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [15:0] EMPTY_CLASS = 16'hFFFF;
  localparam logic [15:0] PRIOR_RESET = 16'd655;
  localparam logic [31:0] MASS_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_MATCH = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_EVICT = 2'd2,
    ACT_DROP  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_LT  = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] y;
    logic        flag;
  } alu_rsp_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       cls;
    logic [31:0]       weight;
  } slot_wr_t;

endpackage

### hw/rtl/tkcet_alu.sv
// Shared mass unit: saturating add, floored subtract and less-than compare.
// Depends on tkcet_pkg.
module tkcet_alu (
  input  tkcet_pkg::alu_req_t req,
  output tkcet_pkg::alu_rsp_t rsp
);
  import tkcet_pkg::*;

  logic [32:0] sum;
  logic [32:0] diff;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign diff = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    rsp.flag = 1'b0;
    unique case (req.op)
      ALU_ADD: rsp.y = sum[32] ? MASS_MAX : sum[31:0];
      ALU_SUB: rsp.y = diff[32] ? 32'd0 : diff[31:0];
      ALU_LT: begin
        rsp.y    = diff[31:0];
        rsp.flag = diff[32];
      end
      default: rsp.y = sum[31:0];
    endcase
  end

endmodule

### hw/rtl/tkcet_slots.sv
// Slot register file: class and mass per slot, one read and one write port.
// Depends on tkcet_pkg.
module tkcet_slots (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tkcet_pkg::SLOT_W-1:0]  rd_addr,
  output logic [15:0]                   rd_class,
  output logic [31:0]                   rd_weight,
  input  tkcet_pkg::slot_wr_t           wr
);
  import tkcet_pkg::*;

  logic [15:0] slot_class  [SLOT_COUNT];
  logic [31:0] slot_weight [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_class[i]  <= EMPTY_CLASS;
        slot_weight[i] <= 32'(PRIOR_RESET);
      end
    end else if (wr.en) begin
      slot_class[wr.addr]  <= wr.cls;
      slot_weight[wr.addr] <= wr.weight;
    end
  end

  assign rd_class  = slot_class[rd_addr];
  assign rd_weight = slot_weight[rd_addr];

endmodule

### hw/rtl/top_k_class_evidence_tracker.sv
// Top level of the top-k class evidence tracker: sequencer, scan state and bucket.
// Depends on tkcet_pkg, tkcet_alu and tkcet_slots.
//
// channel   direction  handshake                payload
// item      in         start & !busy            class_id, increment
// result    out        done (one cycle)         action, slot_index, evicted_class,
//                                               slot_mass, bucket_mass
// config    in         cfg_wr_en                cfg_wr_data (prior_mass)
//
// One slot is scanned per cycle, then the shared unit runs one to four steps,
// then the result is registered in ST_OUT. The steps are ST_SLOT for match or fill,
// ST_BKT for a reserved class, ST_EVID, ST_CMP and ST_BKT for a drop with all slots
// full, those then ST_SLOT for an eviction. done follows ST_OUT, when idle.
// Reset is synchronous and restores empty slots, a zero bucket and the reset prior.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
module top_k_class_evidence_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] class_id,
  input  logic [31:0] increment,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        done,
  output logic [1:0]  action,
  output logic [3:0]  slot_index,
  output logic [15:0] evicted_class,
  output logic [31:0] slot_mass,
  output logic [31:0] bucket_mass
);
  import tkcet_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_EVID = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_BKT  = 7'b0010000,
    ST_SLOT = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] prior_mass;
  logic [31:0] bucket;
  logic [15:0] cls;
  logic [31:0] inc;
  logic [31:0] acc;
  logic        evict;

  logic [SLOT_W-1:0] scan_idx;
  logic              match_found, match_found_next;
  logic [SLOT_W-1:0] match_idx, match_idx_next;
  logic [31:0]       match_w, match_w_next;
  logic              empty_found, empty_found_next;
  logic [SLOT_W-1:0] empty_idx, empty_idx_next;
  logic [SLOT_W-1:0] min_idx, min_idx_next;
  logic [31:0]       min_w, min_w_next;
  logic [15:0]       min_class, min_class_next;

  logic              reserved;
  logic              scan_last;
  logic              scan_first;
  logic              hit;
  logic              is_empty;
  act_t              act_sel;
  logic [SLOT_W-1:0] target;
  logic [SLOT_W-1:0] rd_addr;
  logic [15:0]       rd_class;
  logic [31:0]       rd_weight;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  slot_wr_t slot_wr;

  tkcet_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tkcet_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_class  (rd_class),
    .rd_weight (rd_weight),
    .wr        (slot_wr)
  );

  assign busy       = (state != ST_IDLE);
  assign reserved   = (cls == EMPTY_CLASS);
  assign scan_first = (scan_idx == '0);
  assign scan_last  = (scan_idx == SLOT_W'(SLOT_COUNT - 1));
  assign hit        = (rd_class != EMPTY_CLASS) && (rd_class == cls);
  assign is_empty   = (rd_class == EMPTY_CLASS);
  assign rd_addr    = (state == ST_SCAN) ? scan_idx : target;

  always_comb begin
    priority if (reserved) begin
      act_sel = ACT_DROP;
      target  = min_idx;
    end else if (match_found) begin
      act_sel = ACT_MATCH;
      target  = match_idx;
    end else if (empty_found) begin
      act_sel = ACT_FILL;
      target  = empty_idx;
    end else begin
      act_sel = evict ? ACT_EVICT : ACT_DROP;
      target  = min_idx;
    end
  end

  // per-slot scan: first match, first empty, least mass
  always_comb begin
    match_found_next = scan_first ? 1'b0 : match_found;
    match_idx_next   = match_idx;
    match_w_next     = match_w;
    empty_found_next = scan_first ? 1'b0 : empty_found;
    empty_idx_next   = empty_idx;
    min_idx_next     = min_idx;
    min_w_next       = min_w;
    min_class_next   = min_class;
    if (!match_found_next && hit) begin
      match_found_next = 1'b1;
      match_idx_next   = scan_idx;
      match_w_next     = rd_weight;
    end
    if (!empty_found_next && is_empty) begin
      empty_found_next = 1'b1;
      empty_idx_next   = scan_idx;
    end
    if (scan_first || alu_rsp.flag) begin
      min_idx_next   = scan_idx;
      min_w_next     = rd_weight;
      min_class_next = rd_class;
    end
  end

  always_comb begin
    alu_req.op = ALU_LT;
    alu_req.a  = rd_weight;
    alu_req.b  = min_w;
    unique case (state)
      ST_EVID: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = min_w;
        alu_req.b  = 32'(prior_mass);
      end
      ST_CMP: begin
        alu_req.op = ALU_LT;
        alu_req.a  = acc;
        alu_req.b  = inc;
      end
      ST_BKT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = bucket;
        alu_req.b  = evict ? acc : inc;
      end
      ST_SLOT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = match_found ? match_w : 32'(prior_mass);
        alu_req.b  = inc;
      end
      default: ;
    endcase
  end

  always_comb begin
    slot_wr.en     = (state == ST_SLOT);
    slot_wr.addr   = target;
    slot_wr.cls    = cls;
    slot_wr.weight = alu_rsp.y;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          priority if (reserved) state_next = ST_BKT;
          else if (match_found_next || empty_found_next) state_next = ST_SLOT;
          else state_next = ST_EVID;
        end
      end
      ST_EVID: state_next = ST_CMP;
      ST_CMP:  state_next = ST_BKT;
      ST_BKT:  state_next = evict ? ST_SLOT : ST_OUT;
      ST_SLOT: state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      prior_mass <= PRIOR_RESET;
      bucket     <= 32'd0;
    end else begin
      state <= state_next;
      done  <= (state == ST_OUT);
      if (cfg_wr_en) prior_mass <= cfg_wr_data;
      if (state == ST_BKT) bucket <= alu_rsp.y;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cls      <= class_id;
      inc      <= increment;
      scan_idx <= '0;
      evict    <= 1'b0;
    end
    if (state == ST_SCAN) begin
      scan_idx    <= scan_idx + SLOT_W'(1);
      match_found <= match_found_next;
      match_idx   <= match_idx_next;
      match_w     <= match_w_next;
      empty_found <= empty_found_next;
      empty_idx   <= empty_idx_next;
      min_idx     <= min_idx_next;
      min_w       <= min_w_next;
      min_class   <= min_class_next;
    end
    if (state == ST_EVID) acc <= alu_rsp.y;
    if (state == ST_CMP) evict <= alu_rsp.flag;
    if (state == ST_OUT) begin
      action        <= act_sel;
      slot_index    <= 4'(target);
      evicted_class <= (act_sel == ACT_EVICT) ? min_class : EMPTY_CLASS;
      slot_mass     <= rd_weight;
      bucket_mass   <= bucket;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_evict_class: assert property (@(posedge clk) disable iff (rst)
    (done && action != ACT_EVICT) |-> evicted_class == EMPTY_CLASS)
    else $error("evicted class set without eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (done && action == ACT_EVICT) |-> evicted_class != EMPTY_CLASS)
    else $error("eviction of an empty slot");

endmodule
